// File: hw/rtl/dfks_pkg.sv
// Package for the deduplicating key queue: command and status codes,
// the stored entry layout and the key normalization helpers.
// No dependencies.
package dfks_pkg;

  localparam int LEN_W          = 3;
  localparam int DIGITS_W       = 20;
  localparam int MAX_KEY_DIGITS = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_ADDED   = 3'd0,
    STS_DUP     = 3'd1,
    STS_FULL    = 3'd2,
    STS_REMOVED = 3'd3,
    STS_EMPTY   = 3'd4,
    STS_FOUND   = 3'd5,
    STS_MISSING = 3'd6,
    STS_ENTRY   = 3'd7
  } status_t;

  // one queue entry as held in memory
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [DIGITS_W-1:0] digits;
  } entry_t;

  localparam int ENTRY_W = LEN_W + DIGITS_W;

  // lengths above the digit limit saturate
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(MAX_KEY_DIGITS)) begin
      return LEN_W'(MAX_KEY_DIGITS);
    end
    return len;
  endfunction

  // clear nibbles at or above the key length
  function automatic logic [DIGITS_W-1:0] mask_digits(input logic [DIGITS_W-1:0] d,
                                                      input logic [LEN_W-1:0] len);
    logic [DIGITS_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_KEY_DIGITS; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*4 +: 4] = 4'hF;
      end
    end
    return d & m;
  endfunction

endpackage

// File: hw/rtl/dfks_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module dfks_ram #(
  parameter int WIDTH  = 23,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read, one access per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hw/rtl/dedup_fifo_key_set.sv
// Top level of the deduplicating key queue: command sequencer and queue pointers.
// Depends on dfks_pkg and dfks_ram.
//
// A command is taken when start is high and busy is low. Every command gives
// its results on status/entry_len/entry_digits/last, each for one cycle under
// valid; the receiver must take them as they come. Remove, and any command
// on an empty queue, never sets busy; its result is registered and given in
// the next cycle. Add and search on a queue of N entries walk the entries
// through the single memory port one read per cycle, ending early on a match;
// list gives N results on consecutive cycles. Entries in memory need no
// clearing after reset.
module dedup_fifo_key_set #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [2:0]  key_len,
  input  logic [19:0] key_digits,
  output logic        valid,
  output logic [2:0]  status,
  output logic [2:0]  entry_len,
  output logic [19:0] entry_digits,
  output logic        last
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t state;

  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] issued;
  logic [CW-1:0] checked;
  logic          rd_pend;

  dfks_pkg::cmd_t                    cmd_q;
  logic [dfks_pkg::LEN_W-1:0]        key_len_q;
  logic [dfks_pkg::DIGITS_W-1:0]     key_q;

  dfks_pkg::entry_t rd_entry;
  dfks_pkg::entry_t wr_entry;
  dfks_pkg::entry_t in_entry;
  dfks_pkg::cmd_t   cmd_in;

  logic          acc;
  logic          issue;
  logic          hit;
  logic          last_chk;
  logic          fin_scan;
  logic          add_ok;
  logic          ram_we;
  logic [IW-1:0] ram_addr;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  // normalized incoming key
  always_comb begin
    cmd_in          = dfks_pkg::cmd_t'(cmd);
    in_entry.len    = dfks_pkg::sat_len(key_len);
    in_entry.digits = dfks_pkg::mask_digits(key_digits, in_entry.len);
  end

  // scan datapath and memory port control
  always_comb begin
    acc      = start && (state == S_IDLE);
    issue    = (state != S_IDLE) && (issued < count);
    hit      = (rd_entry.len == key_len_q) && (rd_entry.digits == key_q);
    last_chk = ((checked + CW'(1)) == count);
    fin_scan = (state == S_SCAN) && rd_pend && (hit || last_chk);
    add_ok   = fin_scan && (cmd_q == dfks_pkg::CMD_ADD) && !hit &&
               (count < CW'(QUEUE_DEPTH));
    ram_we   = (acc && (cmd_in == dfks_pkg::CMD_ADD) && (count == '0)) || add_ok;
    ram_addr = ram_we ? tail : rd_ptr;
    if (acc) begin
      wr_entry = in_entry;
    end else begin
      wr_entry.len    = key_len_q;
      wr_entry.digits = key_q;
    end
  end

  assign busy = (state != S_IDLE);

  dfks_ram #(
    .WIDTH (dfks_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wr_entry),
    .rdata(rd_entry)
  );

  // payload registers: latched command and result fields
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_q     <= cmd_in;
      key_len_q <= in_entry.len;
      key_q     <= in_entry.digits;
    end
    status       <= dfks_pkg::STS_ADDED;
    entry_len    <= '0;
    entry_digits <= '0;
    last         <= 1'b1;
    if (acc) begin
      if (cmd_in == dfks_pkg::CMD_ADD) begin
        status <= dfks_pkg::STS_ADDED;
      end else if (count == '0) begin
        status <= dfks_pkg::STS_EMPTY;
      end else begin
        status <= dfks_pkg::STS_REMOVED;
      end
    end else if (fin_scan) begin
      if (cmd_q == dfks_pkg::CMD_ADD) begin
        status <= hit ? dfks_pkg::STS_DUP :
                  (add_ok ? dfks_pkg::STS_ADDED : dfks_pkg::STS_FULL);
      end else begin
        status <= hit ? dfks_pkg::STS_FOUND : dfks_pkg::STS_MISSING;
      end
    end else if (state == S_LIST) begin
      status       <= dfks_pkg::STS_ENTRY;
      entry_len    <= rd_entry.len;
      entry_digits <= rd_entry.digits;
      last         <= last_chk;
    end
  end

  // control: sequencer, queue pointers, read walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      rd_ptr  <= '0;
      issued  <= '0;
      checked <= '0;
      rd_pend <= 1'b0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (ram_we) begin
        tail  <= next_slot(tail);
        count <= count + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          rd_ptr  <= head;
          issued  <= '0;
          checked <= '0;
          rd_pend <= 1'b0;
          if (acc) begin
            if (cmd_in == dfks_pkg::CMD_ADD && count == '0) begin
              valid <= 1'b1;
            end else if (count == '0) begin
              valid <= 1'b1;
            end else if (cmd_in == dfks_pkg::CMD_REMOVE) begin
              head  <= next_slot(head);
              count <= count - CW'(1);
              valid <= 1'b1;
            end else if (cmd_in == dfks_pkg::CMD_LIST) begin
              state <= S_LIST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN, S_LIST: begin
          rd_pend <= issue;
          if (issue) begin
            rd_ptr <= next_slot(rd_ptr);
            issued <= issued + CW'(1);
          end
          if (rd_pend) begin
            checked <= checked + CW'(1);
            if (state == S_LIST) begin
              valid <= 1'b1;
              if (last_chk) begin
                state <= S_IDLE;
              end
            end else if (fin_scan) begin
              valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
